// File: rtl/gllbp_pkg.sv
// ============================================================================
// gllbp_pkg - shared types and constants of the greylist leaky bucket policer
// Request and result beat types, verdict codes, controller states and the
// fixed-point reciprocals used for the division by one thousand.
// ============================================================================
`default_nettype none

package gllbp_pkg;

  // Default table depths
  localparam int unsigned CLIENT_ENTRIES_DEF = 1024;
  localparam int unsigned BUCKET_ENTRIES_DEF = 1024;

  // Milli scale of rate, burst and per-request cost
  localparam int unsigned MILLI = 1000;

  // ceil(2^41 / 1000): exact floor(x / 1000) for any 32-bit x
  localparam logic [31:0] RECIP_Q = 32'd2199023256;
  localparam int unsigned Q_SHIFT = 41;
  // ceil(2^40 / 1000): exact floor(x / 1000) for any 30-bit x
  localparam logic [30:0] RECIP_R = 31'd1099511628;
  localparam int unsigned R_SHIFT = 40;

  // Verdict codes
  localparam logic [2:0] V_NO_RULE = 3'd0;
  localparam logic [2:0] V_NEW     = 3'd1;
  localparam logic [2:0] V_WITHIN  = 3'd2;
  localparam logic [2:0] V_GREY    = 3'd3;
  localparam logic [2:0] V_NEWGREY = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_EVAL,
    ST_LEAK
  } state_e;

  typedef struct packed {
    logic [9:0]  client_index;
    logic [9:0]  bucket_index;
    logic        rule_matched;
    logic [19:0] rate_milli;
    logic [19:0] burst_milli;
    logic [16:0] block_seconds;
    logic [31:0] now_s;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        blocked;
    logic [16:0] retry_s;
    logic [2:0]  verdict;
  } res_t;

  // Leak amount, magnitude and sign of rate * delta / 1000
  typedef struct packed {
    logic        neg;
    logic [42:0] mag;
  } leak_t;

endpackage

`default_nettype wire

// File: rtl/gllbp_ram.sv
// ============================================================================
// gllbp_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module gllbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/gllbp_idx_map.sv
// ============================================================================
// gllbp_idx_map - fold a 10-bit request index onto a table of DEPTH entries
// Remainder by a constant through a reciprocal multiply; no divider.
// ============================================================================
`default_nettype none

module gllbp_idx_map #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic [9:0]    idx_i,
  output logic      [AW-1:0] addr_o
);

  logic [9:0]  rem;
  logic [16:0] rem_wide;

  if (DEPTH >= 1024) begin : g_direct
    assign rem = idx_i;
  end else begin : g_fold
    // ceil(2^20 / DEPTH) gives an exact quotient for every 10-bit index
    localparam int unsigned Recip = ((1 << 20) + DEPTH - 1) / DEPTH;
    logic [29:0] prod;
    logic [9:0]  quot;
    logic [19:0] back;
    assign prod = 30'(idx_i) * 30'(Recip);
    assign quot = prod[29:20];
    assign back = 20'(quot) * 20'(DEPTH);
    assign rem  = idx_i - back[9:0];
  end

  assign rem_wide = {7'b0, rem};
  assign addr_o   = rem_wide[AW-1:0];

endmodule

`default_nettype wire

// File: rtl/gllbp_leak.sv
// ============================================================================
// gllbp_leak - five-stage pipeline for rate * signed(delta) / 1000
// Split |delta| = 1000*q + r, then leak = rate*q + floor(rate*r / 1000),
// which equals the truncating quotient since both terms share the sign.
// ============================================================================
`default_nettype none

module gllbp_leak (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [19:0]          rate_i,
  input  wire logic [31:0]          delta_i,
  output gllbp_pkg::leak_t          leak_o,
  output logic                      valid_o
);

  logic [4:0]  vld_q;

  logic [31:0] mag;
  logic [63:0] p1;
  logic [22:0] q1_q;
  logic [31:0] mag1_q;
  logic [19:0] rate1_q;
  logic        neg1_q;

  logic [31:0] qk;
  logic [31:0] r2;
  logic [22:0] q2_q;
  logic [9:0]  r2_q;
  logic [19:0] rate2_q;
  logic        neg2_q;

  logic [42:0] a3_q;
  logic [29:0] b3_q;
  logic        neg3_q;

  logic [60:0] p4;
  logic [42:0] a4_q;
  logic [20:0] c4_q;
  logic        neg4_q;

  logic [42:0] mag5_q;
  logic        neg5_q;

  assign mag = delta_i[31] ? (~delta_i + 32'd1) : delta_i;
  assign p1  = 64'(mag) * 64'(gllbp_pkg::RECIP_Q);
  assign qk  = 32'(q1_q) * 32'(gllbp_pkg::MILLI);
  assign r2  = mag1_q - qk;
  assign p4  = 61'(b3_q) * 61'(gllbp_pkg::RECIP_R);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // quotient by 1000
    q1_q    <= 23'(p1 >> gllbp_pkg::Q_SHIFT);
    mag1_q  <= mag;
    rate1_q <= rate_i;
    neg1_q  <= delta_i[31];
    // remainder
    q2_q    <= q1_q;
    r2_q    <= r2[9:0];
    rate2_q <= rate1_q;
    neg2_q  <= neg1_q;
    // partial products
    a3_q    <= 43'(rate2_q) * 43'(q2_q);
    b3_q    <= 30'(rate2_q) * 30'(r2_q);
    neg3_q  <= neg2_q;
    // fractional part divided by 1000
    a4_q    <= a3_q;
    c4_q    <= 21'(p4 >> gllbp_pkg::R_SHIFT);
    neg4_q  <= neg3_q;
    // combine
    mag5_q  <= a4_q + 43'(c4_q);
    neg5_q  <= neg4_q;
  end

  assign leak_o.neg = neg5_q;
  assign leak_o.mag = mag5_q;
  assign valid_o    = vld_q[4];

endmodule

`default_nettype wire

// File: rtl/greylist_leaky_bucket_policer.sv
// ============================================================================
// greylist_leaky_bucket_policer - per-client greylist and leaky bucket policer
// Checks a client greylist, updates a rate bucket and answers pass or block.
// ============================================================================
//
// One request beat is taken when start is high and busy is low; every request
// produces exactly one result beat on res_o, shown for a single cycle with
// result_valid_o high, and the receiver cannot stall it. Requests are handled
// one at a time: a request that is answered from the greylist, has no matched
// rule or opens a new bucket goes through index fold, memory read and decision
// before the next accept. A request that updates an existing bucket also
// waits for the five-stage leak pipeline (rate * delta / 1000 through
// reciprocal multiplies) before its decision and write-back. The result
// beat is registered and appears in the cycle after the decision, while
// busy is already low again. After reset the block clears both tables, one
// entry a cycle, and keeps busy high until the larger table has been swept.
// Indices are folded modulo the table depths.
//
`default_nettype none

module greylist_leaky_bucket_policer #(
  parameter int unsigned CLIENT_ENTRIES = gllbp_pkg::CLIENT_ENTRIES_DEF,
  parameter int unsigned BUCKET_ENTRIES = gllbp_pkg::BUCKET_ENTRIES_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire gllbp_pkg::req_t req_i,
  output logic                 result_valid_o,
  output gllbp_pkg::res_t      res_o
);

  localparam int unsigned CAW  = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int unsigned BAW  = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
  localparam int unsigned MAXD = (CLIENT_ENTRIES > BUCKET_ENTRIES) ?
                                 CLIENT_ENTRIES : BUCKET_ENTRIES;
  localparam int unsigned CW   = $clog2(MAXD);

  // Greylist word: {valid, expiry}; bucket word: {valid, excess, last_ms}
  localparam int unsigned GW = 33;
  localparam int unsigned BW = 65;

  gllbp_pkg::state_e state_q, state_d;

  gllbp_pkg::req_t req_q;
  gllbp_pkg::res_t res_q, res_d;
  logic            res_valid_q, res_valid_d;
  logic [CW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [CAW-1:0]  ca_q;
  logic [BAW-1:0]  ba_q;
  logic [31:0]     bex_q;

  logic [CAW-1:0]  ca_map;
  logic [BAW-1:0]  ba_map;

  logic            grey_we;
  logic [CAW-1:0]  grey_waddr;
  logic [GW-1:0]   grey_wdata;
  logic [GW-1:0]   grey_rdata;
  logic            bucket_we;
  logic [BAW-1:0]  bucket_waddr;
  logic [BW-1:0]   bucket_wdata;
  logic [BW-1:0]   bucket_rdata;

  logic            gv;
  logic [31:0]     gexp;
  logic            bv;
  logic [31:0]     bex;
  logic [31:0]     blast;
  logic            grey_hit;
  logic [31:0]     retry_full;

  logic            leak_start;
  logic            leak_valid;
  gllbp_pkg::leak_t leak;

  logic [43:0]     ex_up;
  logic [43:0]     ex_base;
  logic [43:0]     ex_down;
  logic [31:0]     exs;
  logic            over;
  logic [32:0]     exp_sum;
  logic [31:0]     expiry;

  logic            clr_in_client;
  logic            clr_in_bucket;

  // ---------------------------------------------------------------------------
  // Index fold and tables
  // ---------------------------------------------------------------------------
  gllbp_idx_map #(.DEPTH(CLIENT_ENTRIES)) u_cmap (
    .idx_i  (req_q.client_index),
    .addr_o (ca_map)
  );

  gllbp_idx_map #(.DEPTH(BUCKET_ENTRIES)) u_bmap (
    .idx_i  (req_q.bucket_index),
    .addr_o (ba_map)
  );

  gllbp_ram #(.WIDTH(GW), .DEPTH(CLIENT_ENTRIES)) u_grey_ram (
    .clk_i   (clk_i),
    .we_i    (grey_we),
    .waddr_i (grey_waddr),
    .wdata_i (grey_wdata),
    .raddr_i (ca_q),
    .rdata_o (grey_rdata)
  );

  gllbp_ram #(.WIDTH(BW), .DEPTH(BUCKET_ENTRIES)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bucket_we),
    .waddr_i (bucket_waddr),
    .wdata_i (bucket_wdata),
    .raddr_i (ba_q),
    .rdata_o (bucket_rdata)
  );

  assign gv    = grey_rdata[32];
  assign gexp  = grey_rdata[31:0];
  assign bv    = bucket_rdata[64];
  assign bex   = bucket_rdata[63:32];
  assign blast = bucket_rdata[31:0];

  // Still greylisted: expiry lies after the request time
  assign grey_hit   = gv && (req_q.now_s < gexp);
  assign retry_full = gexp - req_q.now_s;

  // ---------------------------------------------------------------------------
  // Leak pipeline, started once the bucket entry is read
  // ---------------------------------------------------------------------------
  gllbp_leak u_leak (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (leak_start),
    .rate_i  (req_q.rate_milli),
    .delta_i (req_q.now_ms - blast),
    .leak_o  (leak),
    .valid_o (leak_valid)
  );

  // New excess: old - leak + 1000, floored at zero, saturated at 2^32-1.
  // A negative delta turns the leak into an addition.
  assign ex_up   = 44'(bex_q) + 44'(leak.mag) + 44'(gllbp_pkg::MILLI);
  assign ex_base = 44'(bex_q) + 44'(gllbp_pkg::MILLI);
  assign ex_down = ex_base - 44'(leak.mag);

  always_comb begin
    if (leak.neg) begin
      exs = (ex_up > 44'hFFFF_FFFF) ? 32'hFFFF_FFFF : ex_up[31:0];
    end else if (44'(leak.mag) >= ex_base) begin
      exs = '0;
    end else begin
      exs = (ex_down > 44'hFFFF_FFFF) ? 32'hFFFF_FFFF : ex_down[31:0];
    end
  end

  assign over    = exs > 32'(req_q.burst_milli);
  assign exp_sum = 33'(req_q.now_s) + 33'(req_q.block_seconds);
  assign expiry  = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

  assign clr_in_client = {1'b0, clr_cnt_q} < (CW+1)'(CLIENT_ENTRIES);
  assign clr_in_bucket = {1'b0, clr_cnt_q} < (CW+1)'(BUCKET_ENTRIES);

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    grey_we      = 1'b0;
    grey_waddr   = ca_q;
    grey_wdata   = {1'b0, gexp};
    bucket_we    = 1'b0;
    bucket_waddr = ba_q;
    bucket_wdata = {1'b1, 32'd0, req_q.now_ms};
    leak_start   = 1'b0;

    case (state_q)
      gllbp_pkg::ST_CLEAR: begin
        // Sweep both tables, dropping every valid bit
        grey_we      = clr_in_client;
        grey_waddr   = clr_cnt_q[CAW-1:0];
        grey_wdata   = '0;
        bucket_we    = clr_in_bucket;
        bucket_waddr = clr_cnt_q[BAW-1:0];
        bucket_wdata = '0;
        if (clr_cnt_q == CW'(MAXD - 1)) begin
          state_d = gllbp_pkg::ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + CW'(1);
        end
      end

      gllbp_pkg::ST_IDLE: begin
        if (start) begin
          state_d = gllbp_pkg::ST_ADDR;
        end
      end

      gllbp_pkg::ST_ADDR: begin
        state_d = gllbp_pkg::ST_READ;
      end

      gllbp_pkg::ST_READ: begin
        state_d = gllbp_pkg::ST_EVAL;
      end

      gllbp_pkg::ST_EVAL: begin
        if (grey_hit) begin
          // Still greylisted: answer with the remaining time
          res_d.blocked = 1'b1;
          res_d.retry_s = retry_full[16:0];
          res_d.verdict = gllbp_pkg::V_GREY;
          res_valid_d   = 1'b1;
          state_d       = gllbp_pkg::ST_IDLE;
        end else begin
          // Drop an expired greylist entry
          grey_we = gv;
          if (!req_q.rule_matched) begin
            res_d.blocked = 1'b0;
            res_d.retry_s = '0;
            res_d.verdict = gllbp_pkg::V_NO_RULE;
            res_valid_d   = 1'b1;
            state_d       = gllbp_pkg::ST_IDLE;
          end else if (!bv) begin
            // Open a fresh bucket at now_ms with no excess
            bucket_we     = 1'b1;
            res_d.blocked = 1'b0;
            res_d.retry_s = '0;
            res_d.verdict = gllbp_pkg::V_NEW;
            res_valid_d   = 1'b1;
            state_d       = gllbp_pkg::ST_IDLE;
          end else begin
            leak_start = 1'b1;
            state_d    = gllbp_pkg::ST_LEAK;
          end
        end
      end

      gllbp_pkg::ST_LEAK: begin
        if (leak_valid) begin
          bucket_we    = 1'b1;
          bucket_wdata = {1'b1, exs, req_q.now_ms};
          res_valid_d  = 1'b1;
          state_d      = gllbp_pkg::ST_IDLE;
          if (over) begin
            // Greylist the client for the rule's duration
            grey_we       = 1'b1;
            grey_wdata    = {1'b1, expiry};
            res_d.blocked = 1'b1;
            res_d.retry_s = req_q.block_seconds;
            res_d.verdict = gllbp_pkg::V_NEWGREY;
          end else begin
            res_d.blocked = 1'b0;
            res_d.retry_s = '0;
            res_d.verdict = gllbp_pkg::V_WITHIN;
          end
        end
      end

      default: begin
        state_d = gllbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gllbp_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers: request beat, folded addresses, old excess, result
  always_ff @(posedge clk_i) begin
    if (state_q == gllbp_pkg::ST_IDLE && start) begin
      req_q <= req_i;
    end
    if (state_q == gllbp_pkg::ST_ADDR) begin
      ca_q <= ca_map;
      ba_q <= ba_map;
    end
    if (state_q == gllbp_pkg::ST_EVAL) begin
      bex_q <= bex;
    end
    res_q <= res_d;
  end

  assign busy           = (state_q != gllbp_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

endmodule

`default_nettype wire

// File: tb/sv/greylist_leaky_bucket_policer_tb.sv
// ============================================================================
// greylist_leaky_bucket_policer_tb - self-checking bench of the request policer
// Sends request beats through the start/busy handshake, predicts each verdict
// from a behavioral copy of the greylist and bucket tables, and compares every
// result beat field by field against the oldest prediction.
// ============================================================================
`default_nettype none

module greylist_leaky_bucket_policer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLIENTS     = gllbp_pkg::CLIENT_ENTRIES_DEF;
  localparam int unsigned BUCKETS     = gllbp_pkg::BUCKET_ENTRIES_DEF;
  // Cycles in which neither side moves a beat before the run is declared hung. Covers
  // the table clearing pass after reset, the slow bucket path and idle bursts.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned REPORT_MAX  = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  gllbp_pkg::req_t req_beat;
  logic result_valid;
  gllbp_pkg::res_t res_beat;

  greylist_leaky_bucket_policer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_beat),
    .result_valid_o (result_valid),
    .res_o          (res_beat)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the policer tables
  // --------------------------------------------------------------------------
  logic        grey_vld  [CLIENTS];
  logic [31:0] grey_exp  [CLIENTS];
  logic        bkt_vld   [BUCKETS];
  logic [31:0] bkt_excess[BUCKETS];
  logic [31:0] bkt_last  [BUCKETS];

  // Verdicts predicted for accepted request beats, oldest first
  gllbp_pkg::res_t verdicts_due[$];

  int unsigned mismatch_cnt;
  bit          idle_en;

  // Traffic clocks for the random part: wall seconds and millisecond counter
  logic [31:0] wall_s;
  logic [31:0] tick_ms;

  // Work out the answer to one request and advance the shadow tables.
  function automatic gllbp_pkg::res_t judge_request(input gllbp_pkg::req_t r);
    gllbp_pkg::res_t ans;
    int unsigned ci;
    int unsigned bi;
    logic [31:0] du;
    longint      delta;
    longint      leak;
    longint      ex;
    logic [32:0] expiry;
    ans = '0;
    ci  = r.client_index % CLIENTS;
    bi  = r.bucket_index % BUCKETS;

    // Greylisted client: block until expiry, else drop the stale entry
    if (grey_vld[ci]) begin
      if (r.now_s < grey_exp[ci]) begin
        ans.blocked = 1'b1;
        ans.retry_s = 17'(grey_exp[ci] - r.now_s);
        ans.verdict = gllbp_pkg::V_GREY;
        return ans;
      end
      grey_vld[ci] = 1'b0;
    end

    if (!r.rule_matched) begin
      ans.verdict = gllbp_pkg::V_NO_RULE;
      return ans;
    end

    if (!bkt_vld[bi]) begin
      bkt_vld[bi]    = 1'b1;
      bkt_excess[bi] = '0;
      bkt_last[bi]   = r.now_ms;
      ans.verdict    = gllbp_pkg::V_NEW;
      return ans;
    end

    // Leak by a signed elapsed time; the quotient truncates toward zero
    du    = r.now_ms - bkt_last[bi];
    delta = longint'(signed'(du));
    leak  = (longint'(r.rate_milli) * delta) / longint'(gllbp_pkg::MILLI);
    ex    = longint'(bkt_excess[bi]) - leak + longint'(gllbp_pkg::MILLI);
    if (ex < 0) ex = 0;
    if (ex > longint'(32'hFFFF_FFFF)) ex = longint'(32'hFFFF_FFFF);
    bkt_excess[bi] = 32'(ex);
    bkt_last[bi]   = r.now_ms;

    if (bkt_excess[bi] > 32'(r.burst_milli)) begin
      // Expiry saturates at the top of the seconds range
      expiry = {1'b0, r.now_s} + 33'(r.block_seconds);
      if (expiry[32]) expiry = 33'h0_FFFF_FFFF;
      grey_vld[ci] = 1'b1;
      grey_exp[ci] = expiry[31:0];
      ans.blocked  = 1'b1;
      ans.retry_s  = r.block_seconds;
      ans.verdict  = gllbp_pkg::V_NEWGREY;
      return ans;
    end

    ans.verdict = gllbp_pkg::V_WITHIN;
    return ans;
  endfunction

  function automatic gllbp_pkg::req_t mk_req(input logic [9:0] ci, input logic [9:0] bi,
                                  input logic m, input logic [19:0] rate,
                                  input logic [19:0] burst, input logic [16:0] dur,
                                  input logic [31:0] ns, input logic [31:0] nms);
    gllbp_pkg::req_t r;
    r.client_index  = ci;
    r.bucket_index  = bi;
    r.rule_matched  = m;
    r.rate_milli    = rate;
    r.burst_milli   = burst;
    r.block_seconds = dur;
    r.now_s         = ns;
    r.now_ms        = nms;
    return r;
  endfunction

  // Build one random request. Most traffic hits a small pool of clients and
  // buckets on slowly advancing clocks so that buckets fill, clients get
  // greylisted and entries expire; the rest is unconstrained noise.
  function automatic gllbp_pkg::req_t random_request();
    gllbp_pkg::req_t r;
    int unsigned pick;
    if ($urandom_range(0, 9) == 0) begin
      return mk_req(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                    1'($urandom_range(0, 1)), 20'($urandom_range(1, 1000000)),
                    20'($urandom_range(0, 1000000)), 17'($urandom_range(1, 86400)),
                    $urandom, $urandom);
    end

    // Advance the clocks: mostly small steps, sometimes backwards or a jump
    pick = $urandom_range(0, 99);
    if (pick < 4)       tick_ms = $urandom;
    else if (pick < 9)  tick_ms = tick_ms - $urandom_range(1, 5000);
    else                tick_ms = tick_ms + $urandom_range(0, 1500);
    pick = $urandom_range(0, 99);
    if (pick < 2)       wall_s = $urandom;
    else if (pick < 3)  wall_s = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else if (pick < 28) wall_s = wall_s + 1;

    r.client_index = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 7))
                                                : 10'($urandom_range(0, 1023));
    r.bucket_index = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 7))
                                                : 10'($urandom_range(0, 1023));
    r.rule_matched = ($urandom_range(0, 9) != 0);

    pick = $urandom_range(0, 9);
    if (pick < 5)      r.rate_milli = 20'($urandom_range(1, 3000));
    else if (pick < 8) r.rate_milli = 20'($urandom_range(1, 1000000));
    else if (pick < 9) r.rate_milli = 20'h7FFFF;
    else               r.rate_milli = 20'd1000000;

    r.burst_milli = ($urandom_range(0, 9) < 6) ? 20'($urandom_range(0, 4000))
                                               : 20'($urandom_range(0, 1000000));

    pick = $urandom_range(0, 9);
    if (pick < 6)      r.block_seconds = 17'($urandom_range(0, 4));
    else if (pick < 9) r.block_seconds = 17'($urandom_range(1, 86400));
    else               r.block_seconds = ($urandom_range(0, 1) != 0) ? 17'd86400
                                                                     : 17'd65535;
    r.now_s  = wall_s;
    r.now_ms = tick_ms;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Call on a rising edge. Holds the beat until it is taken, then records the
  // predicted verdict. start stays high so that a following beat can go
  // back to back without a second assignment in the same step.
  task automatic send_request(input gllbp_pkg::req_t r);
    start    <= 1'b1;
    req_beat <= r;
    do @(posedge clk_i); while (busy);
    verdicts_due.push_back(judge_request(r));
  endtask

  // Drop start for a random burst of cycles when idling is enabled.
  task automatic idle_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Field extremes, every verdict and the corner cases of the bucket math.
  task automatic test_directed();
    gllbp_pkg::req_t seq[$];
    seq.push_back(mk_req(10'd0, 10'd0, 1'b0, 20'd1, 20'd0, 17'd1, 32'd0, 32'd0));
    // New bucket just below the millisecond wrap
    seq.push_back(mk_req(10'd1023, 10'd1023, 1'b1, 20'd1000000, 20'd1000000,
                         17'd86400, 32'hFFFF_FF00, 32'hFFFF_FFF0));
    // Wrap forward by 32 ms at full rate: excess floors at zero
    seq.push_back(mk_req(10'd1023, 10'd1023, 1'b1, 20'd1000000, 20'd0,
                         17'd86400, 32'hFFFF_FF00, 32'h0000_0010));
    // Zero burst: greylist, expiry saturates at the top of the seconds range
    seq.push_back(mk_req(10'd1023, 10'd1023, 1'b1, 20'd1, 20'd0,
                         17'd86400, 32'hFFFF_FF00, 32'h0000_0010));
    seq.push_back(mk_req(10'd1023, 10'd1023, 1'b0, 20'd1, 20'd0,
                         17'd1, 32'hFFFF_FFF0, 32'h0000_0020));
    // Saturated expiry reached: entry cleared, bucket leaks away
    seq.push_back(mk_req(10'd1023, 10'd1023, 1'b1, 20'd1000000, 20'd1000000,
                         17'd1, 32'hFFFF_FFFF, 32'h0000_4000));
    // Clock going backwards raises the excess; zero greylist duration
    seq.push_back(mk_req(10'd5, 10'd5, 1'b1, 20'd1000, 20'd1000, 17'd0,
                         32'd100, 32'd1000000));
    seq.push_back(mk_req(10'd5, 10'd5, 1'b1, 20'd1000000, 20'd1000000, 17'd0,
                         32'd100, 32'd0));
    // Zero-duration entry has already expired
    seq.push_back(mk_req(10'd5, 10'd6, 1'b0, 20'd1, 20'd0, 17'd1, 32'd100, 32'd5));
    // Most negative delta: excess saturates at all ones
    seq.push_back(mk_req(10'd6, 10'd5, 1'b1, 20'd1000000, 20'd1000000, 17'd1,
                         32'd200, 32'h8000_0000));
    // Zero rate: no leak, still saturated
    seq.push_back(mk_req(10'd7, 10'd5, 1'b1, 20'd0, 20'd1000000, 17'd17,
                         32'd300, 32'h8000_0000));
    seq.push_back(mk_req(10'd7, 10'd5, 1'b1, 20'd1, 20'd0, 17'd1, 32'd310, 32'd0));
    // Burst boundary: excess equal to the burst passes
    seq.push_back(mk_req(10'd8, 10'd9, 1'b1, 20'h7FFFF, 20'h7FFFF, 17'd65535,
                         32'd400, 32'd1000));
    seq.push_back(mk_req(10'd8, 10'd9, 1'b1, 20'h7FFFF, 20'h7FFFF, 17'd65535,
                         32'd400, 32'd3000));
    seq.push_back(mk_req(10'd8, 10'd9, 1'b1, 20'd1, 20'd1000, 17'd65535,
                         32'd400, 32'd3000));
    // Small negative leak truncates toward zero
    seq.push_back(mk_req(10'd9, 10'd9, 1'b1, 20'd3, 20'd1000000, 17'd65535,
                         32'd400, 32'd2999));
    seq.push_back(mk_req(10'd8, 10'd9, 1'b1, 20'd1, 20'd999, 17'd65535,
                         32'd400, 32'd3001));
    seq.push_back(mk_req(10'd8, 10'd9, 1'b1, 20'd1, 20'd999, 17'd65535,
                         32'd401, 32'd3001));
    // Alternating index bits
    seq.push_back(mk_req(10'h2AA, 10'h155, 1'b1, 20'd524288, 20'd524288, 17'd65536,
                         32'h5555_5555, 32'hAAAA_AAAA));
    seq.push_back(mk_req(10'h155, 10'h2AA, 1'b1, 20'd524288, 20'd524288, 17'd65536,
                         32'hAAAA_AAAA, 32'h5555_5555));
    seq.push_back(mk_req(10'h155, 10'h2AA, 1'b1, 20'd1, 20'd0, 17'd65536,
                         32'hAAAA_AAAA, 32'h5555_5555));
    foreach (seq[i]) begin
      send_request(seq[i]);
      idle_gap();
    end
  endtask

  // Random traffic with idle bursts switched on and off in stretches.
  task automatic test_random_idle(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) idle_en = ($urandom_range(0, 2) != 0);
      send_request(random_request());
      idle_gap();
    end
  endtask

  // Closing stretch: beats back to back, no idling at all.
  task automatic test_random_streaming(input int unsigned n);
    idle_en = 1'b0;
    for (int unsigned i = 0; i < n; i++) send_request(random_request());
  endtask

  // --------------------------------------------------------------------------
  // Result side: compare each result beat with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gllbp_pkg::res_t want;
    if (rst_ni && result_valid) begin
      if (verdicts_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("[%0t] unexpected result beat: blocked=%0d retry=%0d verdict=%0d",
                   $realtime, res_beat.blocked, res_beat.retry_s, res_beat.verdict);
      end else begin
        want = verdicts_due.pop_front();
        if (res_beat.blocked !== want.blocked || res_beat.retry_s !== want.retry_s
            || res_beat.verdict !== want.verdict) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"[%0t] mismatch: exp blocked=%0d retry=%0d verdict=%0d,",
                      " got blocked=%0d retry=%0d verdict=%0d"},
                     $realtime, want.blocked, want.retry_s, want.verdict,
                     res_beat.blocked, res_beat.retry_s, res_beat.verdict);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a beat
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    req_beat     <= '0;
    idle_en       = 1'b1;
    wall_s        = 32'd1000;
    tick_ms       = 32'd5000;
    foreach (grey_vld[i]) grey_vld[i] = 1'b0;
    foreach (bkt_vld[i]) bkt_vld[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_idle(1080);
    test_random_streaming(350);
    start <= 1'b0;

    // Drain: every predicted verdict must come back; the watchdog covers a hang
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
